// ----- src/cfgdt_pkg.sv -----
// shared types, codes and sizes for the configuration-space device table
`timescale 1ns / 1ps

package cfgdt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	localparam logic [15:0] VENDOR_NONE = 16'hffff;
	localparam logic [31:0] DATA_MISS = 32'hffff_ffff;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] bus_num;
		logic [4:0] device_num;
		logic [2:0] function_num;
		logic [15:0] vendor_id;
		logic [15:0] device_id;
		logic [11:0] reg_offset;
	} in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0] status;
	} out_t;

	// sequencer to table
	typedef struct packed {
		logic clear;
		logic wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [15:0] wr_loc;
		logic [15:0] wr_vendor;
		logic [15:0] wr_device;
		logic [IDX_W-1:0] loc_addr;
		logic [IDX_W-1:0] id_addr;
	} tbl_ctl_t;

	// table to sequencer, registered read data
	typedef struct packed {
		logic valid;
		logic [15:0] loc;
		logic [15:0] vendor;
		logic [15:0] device;
	} tbl_rd_t;

endpackage

// ----- src/config_space_device_table_unit.sv -----
// top level of the emulated configuration-space device table
// Usage:
//   An item (add, read or clear) is taken at a rising edge with start high and
//   busy low. Exactly one result follows per item: it sits on result for one
//   cycle, marked by done, and is taken at the edge that ends that cycle.
//   The receiver cannot stall; each result beat is simply gone after its cycle.
// Throughput and scan:
//   Clear, unused kinds and an add with vendor 0 or 0xFFFF: done rises at the
//   accepting edge itself, busy stays low, so one item per cycle.
//   Add and read walk the table one entry a cycle through the single key
//   comparator, reading one location word per cycle from the entry memory.
//   A matching entry ends the walk early. Worst case: an add or read miss
//   compares every entry before done rises, and a read hit on the last entry
//   also goes through S_RESP; busy falls in the same cycle as done rises.
// Reset:
//   arst_n low clears all valid bits and the sequencer; the table starts empty
//   and needs no clearing pass.
`timescale 1ns / 1ps

module config_space_device_table_unit
	import cfgdt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  in_t   item,
	output logic  busy,
	output logic  done,
	output out_t  result
);

	tbl_ctl_t ctl;
	tbl_rd_t rd;
	logic accept;
	logic res_vld;
	out_t res;

	assign accept = start && !busy;

	cfgdt_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.rd      (rd),
		.ctl     (ctl),
		.busy    (busy),
		.res_vld (res_vld),
		.res     (res)
	);

	cfgdt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rd     (rd)
	);

	// result register frees the sequencer in the cycle it finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			result <= res;
		end
	end

endmodule

// ----- src/cfgdt_table.sv -----
// entry storage: valid flops plus location and id memories with registered reads
`timescale 1ns / 1ps

module cfgdt_table
	import cfgdt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  tbl_ctl_t  ctl,
	output tbl_rd_t   rd
);

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [15:0] loc_mem [TABLE_ENTRIES];
	logic [15:0] vendor_mem [TABLE_ENTRIES];
	logic [15:0] device_mem [TABLE_ENTRIES];

	logic rd_valid_q;
	logic [15:0] rd_loc_q;
	logic [15:0] rd_vendor_q;
	logic [15:0] rd_device_q;

	assign rd = {rd_valid_q, rd_loc_q, rd_vendor_q, rd_device_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[ctl.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			loc_mem[ctl.wr_addr] <= ctl.wr_loc;
			vendor_mem[ctl.wr_addr] <= ctl.wr_vendor;
			device_mem[ctl.wr_addr] <= ctl.wr_device;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[ctl.loc_addr];
		end
	end

	always_ff @(posedge clk) begin
		rd_loc_q <= loc_mem[ctl.loc_addr];
		rd_vendor_q <= vendor_mem[ctl.id_addr];
		rd_device_q <= device_mem[ctl.id_addr];
	end

`ifndef SYNTHESIS
	a_no_clear_and_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.clear && ctl.wr_en))
		else $error("table clear and write in the same cycle");
`endif

endmodule

// ----- src/cfgdt_seq.sv -----
// scan sequencer with the shared key comparator
`timescale 1ns / 1ps

module cfgdt_seq
	import cfgdt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  in_t       item,
	input  tbl_rd_t   rd,
	output tbl_ctl_t  ctl,
	output logic      busy,
	output logic      res_vld,
	output out_t      res
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q, state_d;
	logic [1:0] kind_q;
	logic [15:0] key_q;
	logic [15:0] vendor_q;
	logic [15:0] device_q;
	logic off_zero_q;
	logic [IDX_W-1:0] addr_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic cmp_vld_q;
	logic free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	logic bad_vendor;
	logic hit;
	logic last;
	logic free_now;
	logic [IDX_W-1:0] free_idx_now;

	assign bad_vendor = (item.vendor_id == '0) || (item.vendor_id == VENDOR_NONE);
	assign hit = cmp_vld_q && rd.valid && (rd.loc == key_q);
	assign last = cmp_vld_q && (cmp_idx_q == LAST_IDX);
	assign free_now = free_found_q || !rd.valid;
	assign free_idx_now = free_found_q ? free_idx_q : cmp_idx_q;
	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		res_vld = 1'b0;
		res = '0;
		ctl = '0;
		ctl.loc_addr = addr_q;
		ctl.id_addr = cmp_idx_q;
		ctl.wr_loc = key_q;
		ctl.wr_vendor = vendor_q;
		ctl.wr_device = device_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item.kind)
						KIND_ADD: begin
							if (bad_vendor) begin
								res_vld = 1'b1;
								res.status = ST_REFUSED;
							end else begin
								state_d = S_SCAN;
							end
						end
						KIND_READ: state_d = S_SCAN;
						KIND_CLEAR: begin
							ctl.clear = 1'b1;
							res_vld = 1'b1;
						end
						default: res_vld = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					if (kind_q == KIND_READ) begin
						state_d = S_RESP;
					end else begin
						ctl.wr_en = 1'b1;
						ctl.wr_addr = cmp_idx_q;
						res_vld = 1'b1;
						state_d = S_IDLE;
					end
				end else if (last) begin
					res_vld = 1'b1;
					state_d = S_IDLE;
					if (kind_q == KIND_READ) begin
						res.read_data = DATA_MISS;
						res.status = ST_MISS;
					end else if (free_now) begin
						ctl.wr_en = 1'b1;
						ctl.wr_addr = free_idx_now;
					end else begin
						res.status = ST_REFUSED;
					end
				end
			end
			S_RESP: begin
				res_vld = 1'b1;
				res.read_data = off_zero_q ? {rd.device, rd.vendor} : '0;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			addr_q <= '0;
			cmp_idx_q <= '0;
			cmp_vld_q <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				addr_q <= '0;
				cmp_vld_q <= 1'b0;
				free_found_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				// one entry issued per cycle, compared the cycle after
				cmp_idx_q <= addr_q;
				cmp_vld_q <= 1'b1;
				if (addr_q != LAST_IDX) begin
					addr_q <= addr_q + 1'b1;
				end
				if (cmp_vld_q && !rd.valid && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q <= cmp_idx_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= item.kind;
			key_q <= {item.bus_num, item.device_num, item.function_num};
			vendor_q <= item.vendor_id;
			device_q <= item.device_id;
			off_zero_q <= (item.reg_offset[7:2] == '0);
		end
	end

`ifndef SYNTHESIS
	a_write_only_on_add: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> (state_q == S_SCAN) && (kind_q == KIND_ADD))
		else $error("table write outside an add scan");
	a_resp_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP) |-> ($past(state_q) == S_SCAN) && $past(hit))
		else $error("read response without a hit");
	a_miss_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld && (res.status == ST_MISS)) |-> (kind_q == KIND_READ) && last)
		else $error("miss reported outside a finished read scan");
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld && busy) |=> !busy)
		else $error("sequencer stayed busy after its result");
`endif

endmodule

// ----- verif/tb_config_space_device_table_unit.sv -----
// testbench for the configuration-space device table: directed rows, then bursty random traffic
`timescale 1ns / 1ps

module tb_config_space_device_table_unit;
	import cfgdt_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int N_RANDOM = 1700;
	localparam int POOL_KEYS = 24;
	localparam int DRAIN_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		in_t beat;
		bit pinned;
		out_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	in_t item;
	logic busy;
	logic done;
	out_t result;

	// shadow copy of the function table
	bit ent_valid[TABLE_ENTRIES];
	logic [15:0] ent_loc[TABLE_ENTRIES];
	logic [15:0] ent_ven[TABLE_ENTRIES];
	logic [15:0] ent_dev[TABLE_ENTRIES];

	logic [15:0] key_pool[POOL_KEYS];
	out_t expected_q[$];
	int mismatches = 0;

	config_space_device_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_config_space_device_table_unit: FAIL");
		$finish;
	end

	function automatic out_t devtab_apply(in_t it);
		out_t r;
		logic [15:0] key;
		int hit;
		int slot;
		r.read_data = '0;
		r.status = ST_OK;
		key = {it.bus_num, it.device_num, it.function_num};
		hit = -1;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (hit < 0 && ent_valid[i] && ent_loc[i] == key)
				hit = i;
		case (it.kind)
			KIND_ADD: begin
				if (it.vendor_id == 16'h0000 || it.vendor_id == VENDOR_NONE) begin
					r.status = ST_REFUSED;
				end else begin
					slot = hit;
					for (int i = 0; i < TABLE_ENTRIES; i++)
						if (slot < 0 && !ent_valid[i])
							slot = i;
					if (slot < 0) begin
						r.status = ST_REFUSED;
					end else begin
						ent_valid[slot] = 1'b1;
						ent_loc[slot] = key;
						ent_ven[slot] = it.vendor_id;
						ent_dev[slot] = it.device_id;
					end
				end
			end
			KIND_READ: begin
				if (hit < 0) begin
					r.read_data = DATA_MISS;
					r.status = ST_MISS;
				end else if ((it.reg_offset & 12'h0fc) == 12'h000) begin
					r.read_data = {ent_dev[hit], ent_ven[hit]};
				end
			end
			KIND_CLEAR: begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					ent_valid[i] = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic in_t beat_of(logic [1:0] k, logic [7:0] b, logic [4:0] d, logic [2:0] f,
			logic [15:0] ven, logic [15:0] did, logic [11:0] off);
		in_t it;
		it.kind = k;
		it.bus_num = b;
		it.device_num = d;
		it.function_num = f;
		it.vendor_id = ven;
		it.device_id = did;
		it.reg_offset = off;
		return it;
	endfunction

	function automatic row_t row(in_t b, bit p, logic [31:0] d, logic [1:0] s);
		row_t r;
		r.beat = b;
		r.pinned = p;
		r.want.read_data = d;
		r.want.status = s;
		return r;
	endfunction

	function automatic void refresh_pool();
		for (int i = 0; i < POOL_KEYS; i++)
			key_pool[i] = 16'($urandom);
	endfunction

	function automatic in_t random_beat();
		in_t it;
		int pick;
		logic [15:0] key;
		it.kind = 2'($urandom);
		it.bus_num = 8'($urandom);
		it.device_num = 5'($urandom);
		it.function_num = 3'($urandom);
		it.vendor_id = 16'($urandom);
		it.device_id = 16'($urandom);
		it.reg_offset = 12'($urandom);
		pick = $urandom_range(0, 99);
		key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
		if (pick < 72 || (pick >= 85 && pick < 90))
			{it.bus_num, it.device_num, it.function_num} = key;
		if (pick < 40) begin
			it.kind = KIND_ADD;
		end else if (pick < 80) begin
			it.kind = KIND_READ;
			// in half the reads hit the id word or the words at 0x08/0x0c, upper offset bits still random
			case ($urandom_range(0, 3))
				0: it.reg_offset = {4'($urandom), 8'h00};
				1: it.reg_offset = {4'($urandom), ($urandom_range(0, 1) ? 8'h08 : 8'h0c)};
				default: ;
			endcase
		end else if (pick < 81) begin
			it.kind = KIND_CLEAR;
		end else if (pick < 85) begin
			it.kind = KIND_UNUSED;
		end else if (pick < 90) begin
			it.kind = KIND_ADD;
			it.vendor_id = $urandom_range(0, 1) ? VENDOR_NONE : 16'h0000;
		end else if (it.kind == KIND_CLEAR) begin
			// noise stays away from clear so the table can fill up
			it.kind = KIND_UNUSED;
		end
		return it;
	endfunction

	task automatic send_beat(input in_t it, input bit pinned, input out_t want);
		out_t pred;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		pred = devtab_apply(it);
		expected_q.push_back(pinned ? want : pred);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained(input int limit, output bit ok);
		int n;
		n = 0;
		start <= 1'b0;
		while (expected_q.size() != 0 && n < limit) begin
			@(posedge clk);
			n++;
		end
		ok = (expected_q.size() == 0);
	endtask

	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: data %h status %0d",
						result.read_data, result.status);
			end else begin
				want = expected_q.pop_front();
				if (result.read_data !== want.read_data || result.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected data %h status %0d, got data %h status %0d",
							want.read_data, want.status, result.read_data, result.status);
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		in_t it;
		int sent;
		int burst;
		bit ok;
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		refresh_pool();

		// empty table, refused vendors, unused kind
		rows.push_back(row(beat_of(KIND_READ, 8'h00, 5'd0, 3'd0, 16'h0, 16'h0, 12'h000),
			1'b1, DATA_MISS, ST_MISS));
		rows.push_back(row(beat_of(KIND_ADD, 8'h12, 5'd3, 3'd1, 16'h0000, 16'h5555, 12'h000),
			1'b1, 32'h0, ST_REFUSED));
		rows.push_back(row(beat_of(KIND_ADD, 8'h12, 5'd3, 3'd1, 16'hffff, 16'haaaa, 12'hfff),
			1'b1, 32'h0, ST_REFUSED));
		rows.push_back(row(beat_of(KIND_UNUSED, 8'hff, 5'd31, 3'd7, 16'hffff, 16'hffff, 12'hfff),
			1'b1, 32'h0, ST_OK));
		// lowest key, then offsets around the id word
		rows.push_back(row(beat_of(KIND_ADD, 8'h00, 5'd0, 3'd0, 16'h0001, 16'h0000, 12'hfff),
			1'b0, 32'h0, ST_OK));
		rows.push_back(row(beat_of(KIND_READ, 8'h00, 5'd0, 3'd0, 16'hffff, 16'hffff, 12'h000),
			1'b0, 32'h0, ST_OK));
		rows.push_back(row(beat_of(KIND_READ, 8'h00, 5'd0, 3'd0, 16'h0, 16'h0, 12'hf03),
			1'b0, 32'h0, ST_OK));
		rows.push_back(row(beat_of(KIND_READ, 8'h00, 5'd0, 3'd0, 16'h0, 16'h0, 12'h008),
			1'b0, 32'h0, ST_OK));
		rows.push_back(row(beat_of(KIND_READ, 8'h00, 5'd0, 3'd0, 16'h0, 16'h0, 12'h00c),
			1'b0, 32'h0, ST_OK));
		rows.push_back(row(beat_of(KIND_READ, 8'h00, 5'd0, 3'd0, 16'h0, 16'h0, 12'h0fc),
			1'b0, 32'h0, ST_OK));
		// update in place, and a refused vendor must not touch the entry
		rows.push_back(row(beat_of(KIND_ADD, 8'h00, 5'd0, 3'd0, 16'hfffe, 16'hffff, 12'h000),
			1'b0, 32'h0, ST_OK));
		rows.push_back(row(beat_of(KIND_ADD, 8'h00, 5'd0, 3'd0, 16'h0000, 16'h1111, 12'h000),
			1'b1, 32'h0, ST_REFUSED));
		rows.push_back(row(beat_of(KIND_READ, 8'h00, 5'd0, 3'd0, 16'h0, 16'h0, 12'h000),
			1'b0, 32'h0, ST_OK));
		// highest key, neighbor key misses
		rows.push_back(row(beat_of(KIND_ADD, 8'hff, 5'd31, 3'd7, 16'h1234, 16'habcd, 12'h000),
			1'b0, 32'h0, ST_OK));
		rows.push_back(row(beat_of(KIND_READ, 8'hff, 5'd31, 3'd7, 16'h0, 16'h0, 12'h100),
			1'b0, 32'h0, ST_OK));
		rows.push_back(row(beat_of(KIND_READ, 8'hff, 5'd31, 3'd6, 16'h0, 16'h0, 12'h000),
			1'b1, DATA_MISS, ST_MISS));
		// clear with every other field set, then reuse a slot
		rows.push_back(row(beat_of(KIND_CLEAR, 8'hff, 5'd31, 3'd7, 16'hffff, 16'hffff, 12'hfff),
			1'b1, 32'h0, ST_OK));
		rows.push_back(row(beat_of(KIND_READ, 8'hff, 5'd31, 3'd7, 16'h0, 16'h0, 12'h000),
			1'b1, DATA_MISS, ST_MISS));
		rows.push_back(row(beat_of(KIND_READ, 8'h00, 5'd0, 3'd0, 16'h0, 16'h0, 12'h000),
			1'b1, DATA_MISS, ST_MISS));
		rows.push_back(row(beat_of(KIND_ADD, 8'hff, 5'd31, 3'd7, 16'h8001, 16'h0000, 12'h000),
			1'b0, 32'h0, ST_OK));
		rows.push_back(row(beat_of(KIND_READ, 8'hff, 5'd31, 3'd7, 16'h0, 16'h0, 12'hf00),
			1'b0, 32'h0, ST_OK));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_beat(rows[i].beat, rows[i].pinned, rows[i].want);
			if ($urandom_range(0, 2) == 0)
				idle_cycles($urandom_range(1, 6));
		end
		wait_drained(DRAIN_LIMIT, ok);
		@(posedge clk);

		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 24);
			for (int j = 0; j < burst && sent < N_RANDOM; j++) begin
				it = random_beat();
				send_beat(it, 1'b0, '0);
				if (it.kind == KIND_CLEAR)
					refresh_pool();
				sent++;
				if (sent == N_RANDOM / 2) begin
					// hold off until the block has emptied out
					wait_drained(DRAIN_LIMIT, ok);
					@(posedge clk);
				end else if ($urandom_range(0, 7) == 0) begin
					idle_cycles($urandom_range(1, 3));
				end
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 20));
		end

		wait_drained(DRAIN_LIMIT, ok);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ok && mismatches == 0 && expected_q.size() == 0)
			$display("tb_config_space_device_table_unit: PASS");
		else
			$display("tb_config_space_device_table_unit: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
src/cfgdt_pkg.sv
src/cfgdt_table.sv
src/cfgdt_seq.sv
src/config_space_device_table_unit.sv
verif/tb_config_space_device_table_unit.sv
